// ===== src/kcsr_pkg.sv =====
// ----------------------------------------------------------------------------
// kcsr_pkg
// Shared types, codes and arithmetic helpers for the cluster swap refiner.
// ----------------------------------------------------------------------------
`default_nettype none

package kcsr_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int CID_BITS  = 4;
  localparam int WIDE_BITS = 40;

  localparam int VC_RESET = 64;
  localparam int CC_RESET = 16;

  localparam logic [1:0] OPC_EDGE    = 2'd0;
  localparam logic [1:0] OPC_CLUSTER = 2'd1;
  localparam logic [1:0] OPC_RUN     = 2'd2;

  localparam logic [1:0] REG_VERTEX_COUNT  = 2'd0;
  localparam logic [1:0] REG_CLUSTER_COUNT = 2'd1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  vertex_a;
    logic [5:0]  vertex_b;
    logic [15:0] edge_weight;
    logic [3:0]  cluster_id;
  } in_item_t;

  typedef struct packed {
    logic [5:0] out_vertex;
    logic [3:0] out_cluster;
    logic       last;
  } out_item_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_EDGE2, S_PAIR, S_CL_RD, S_CL_CAP, S_CL_CHK,
    S_SU_RD, S_SU_ACC, S_SU_WR, S_SR_INIT, S_SR_A, S_SR_ALAT, S_SR_B,
    S_SR_BCALC, S_SR_END, S_UP_RD1, S_UP_RD2, S_UP_WR, S_PF_INIT, S_PF_RD,
    S_PF_ACC, S_CM_RD, S_CM_W1, S_CM_W2, S_PAIR_ADV, S_EM_RD, S_EM_LD
  } state_t;

  typedef enum logic [4:0] {
    OP_CLEAR, OP_IDLE, OP_EDGE2, OP_PAIR, OP_CL_RD, OP_CL_CAP, OP_CL_CHK,
    OP_SU_RD, OP_SU_ACC, OP_SU_WR, OP_SR_INIT, OP_SR_A, OP_SR_ALAT, OP_SR_B,
    OP_SR_BCALC, OP_SR_END, OP_UP_RD1, OP_UP_RD2, OP_UP_WR, OP_PF_INIT, OP_PF_RD,
    OP_PF_ACC, OP_CM_RD, OP_CM_W1, OP_CM_W2, OP_PAIR_ADV, OP_EM_RD, OP_EM_LD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic       fire;
    logic [1:0] opcode;
    logic       edge_ok;
    logic       clr_done;
    logic       pair_ok;
    logic       v_last;
    logic       u_last;
    logic       size_ok;
    logic       steps_full;
    logic       a_end;
    logic       elig_a;
    logic       b_end;
    logic       elig_b;
    logic       found;
    logic       k_at_steps;
    logic       k_at_commit;
    logic       out_free;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_BITS-1:0] x);
    logic signed [31:0] r;
    if ((&x[WIDE_BITS-1:31]) || !(|x[WIDE_BITS-1:31])) r = x[31:0];
    else if (x[WIDE_BITS-1]) r = 32'sh8000_0000;
    else r = 32'sh7fff_ffff;
    return r;
  endfunction

  function automatic logic signed [WIDE_BITS-1:0] sx(input logic signed [31:0] x);
    return {{(WIDE_BITS-32){x[31]}}, x};
  endfunction

endpackage

`default_nettype wire

// ===== src/kcsr_ram.sv =====
// ----------------------------------------------------------------------------
// kcsr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kcsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/kcsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// kcsr_ctrl
// Sequencer for loads, pairwise refinement passes and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module kcsr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  kcsr_pkg::status_t status,
  output kcsr_pkg::cmd_t    cmd,
  output logic              in_stall
);

  kcsr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kcsr_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kcsr_pkg::S_CLEAR: begin
        if (status.clr_done) state_next = kcsr_pkg::S_IDLE;
      end
      kcsr_pkg::S_IDLE: begin
        if (status.fire) begin
          unique case (status.opcode)
            kcsr_pkg::OPC_EDGE: begin
              if (status.edge_ok) state_next = kcsr_pkg::S_EDGE2;
            end
            kcsr_pkg::OPC_RUN: begin
              state_next = kcsr_pkg::S_PAIR;
            end
            default: state_next = kcsr_pkg::S_IDLE;
          endcase
        end
      end
      kcsr_pkg::S_EDGE2:  state_next = kcsr_pkg::S_IDLE;
      kcsr_pkg::S_PAIR: begin
        state_next = status.pair_ok ? kcsr_pkg::S_CL_RD : kcsr_pkg::S_EM_RD;
      end
      kcsr_pkg::S_CL_RD:  state_next = kcsr_pkg::S_CL_CAP;
      kcsr_pkg::S_CL_CAP: begin
        state_next = status.v_last ? kcsr_pkg::S_CL_CHK : kcsr_pkg::S_CL_RD;
      end
      kcsr_pkg::S_CL_CHK: begin
        state_next = status.size_ok ? kcsr_pkg::S_SU_RD : kcsr_pkg::S_PAIR_ADV;
      end
      kcsr_pkg::S_SU_RD:  state_next = kcsr_pkg::S_SU_ACC;
      kcsr_pkg::S_SU_ACC: begin
        state_next = status.u_last ? kcsr_pkg::S_SU_WR : kcsr_pkg::S_SU_RD;
      end
      kcsr_pkg::S_SU_WR: begin
        state_next = status.v_last ? kcsr_pkg::S_SR_INIT : kcsr_pkg::S_SU_RD;
      end
      kcsr_pkg::S_SR_INIT: begin
        state_next = status.steps_full ? kcsr_pkg::S_PF_INIT : kcsr_pkg::S_SR_A;
      end
      kcsr_pkg::S_SR_A: begin
        if (status.a_end) state_next = kcsr_pkg::S_SR_END;
        else if (status.elig_a) state_next = kcsr_pkg::S_SR_ALAT;
      end
      kcsr_pkg::S_SR_ALAT: state_next = kcsr_pkg::S_SR_B;
      kcsr_pkg::S_SR_B: begin
        if (status.b_end) state_next = kcsr_pkg::S_SR_A;
        else if (status.elig_b) state_next = kcsr_pkg::S_SR_BCALC;
      end
      kcsr_pkg::S_SR_BCALC: state_next = kcsr_pkg::S_SR_B;
      kcsr_pkg::S_SR_END: begin
        state_next = status.found ? kcsr_pkg::S_UP_RD1 : kcsr_pkg::S_PF_INIT;
      end
      kcsr_pkg::S_UP_RD1: state_next = kcsr_pkg::S_UP_RD2;
      kcsr_pkg::S_UP_RD2: state_next = kcsr_pkg::S_UP_WR;
      kcsr_pkg::S_UP_WR: begin
        state_next = status.v_last ? kcsr_pkg::S_SR_INIT : kcsr_pkg::S_UP_RD1;
      end
      kcsr_pkg::S_PF_INIT: state_next = kcsr_pkg::S_PF_RD;
      kcsr_pkg::S_PF_RD: begin
        state_next = status.k_at_steps ? kcsr_pkg::S_CM_RD : kcsr_pkg::S_PF_ACC;
      end
      kcsr_pkg::S_PF_ACC: state_next = kcsr_pkg::S_PF_RD;
      kcsr_pkg::S_CM_RD: begin
        state_next = status.k_at_commit ? kcsr_pkg::S_PAIR_ADV : kcsr_pkg::S_CM_W1;
      end
      kcsr_pkg::S_CM_W1:    state_next = kcsr_pkg::S_CM_W2;
      kcsr_pkg::S_CM_W2:    state_next = kcsr_pkg::S_CM_RD;
      kcsr_pkg::S_PAIR_ADV: state_next = kcsr_pkg::S_PAIR;
      kcsr_pkg::S_EM_RD:    state_next = kcsr_pkg::S_EM_LD;
      kcsr_pkg::S_EM_LD: begin
        if (status.out_free) begin
          state_next = status.v_last ? kcsr_pkg::S_IDLE : kcsr_pkg::S_EM_RD;
        end
      end
      default: state_next = kcsr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != kcsr_pkg::S_IDLE);
    unique case (state)
      kcsr_pkg::S_CLEAR:    cmd.op = kcsr_pkg::OP_CLEAR;
      kcsr_pkg::S_IDLE:     cmd.op = kcsr_pkg::OP_IDLE;
      kcsr_pkg::S_EDGE2:    cmd.op = kcsr_pkg::OP_EDGE2;
      kcsr_pkg::S_PAIR:     cmd.op = kcsr_pkg::OP_PAIR;
      kcsr_pkg::S_CL_RD:    cmd.op = kcsr_pkg::OP_CL_RD;
      kcsr_pkg::S_CL_CAP:   cmd.op = kcsr_pkg::OP_CL_CAP;
      kcsr_pkg::S_CL_CHK:   cmd.op = kcsr_pkg::OP_CL_CHK;
      kcsr_pkg::S_SU_RD:    cmd.op = kcsr_pkg::OP_SU_RD;
      kcsr_pkg::S_SU_ACC:   cmd.op = kcsr_pkg::OP_SU_ACC;
      kcsr_pkg::S_SU_WR:    cmd.op = kcsr_pkg::OP_SU_WR;
      kcsr_pkg::S_SR_INIT:  cmd.op = kcsr_pkg::OP_SR_INIT;
      kcsr_pkg::S_SR_A:     cmd.op = kcsr_pkg::OP_SR_A;
      kcsr_pkg::S_SR_ALAT:  cmd.op = kcsr_pkg::OP_SR_ALAT;
      kcsr_pkg::S_SR_B:     cmd.op = kcsr_pkg::OP_SR_B;
      kcsr_pkg::S_SR_BCALC: cmd.op = kcsr_pkg::OP_SR_BCALC;
      kcsr_pkg::S_SR_END:   cmd.op = kcsr_pkg::OP_SR_END;
      kcsr_pkg::S_UP_RD1:   cmd.op = kcsr_pkg::OP_UP_RD1;
      kcsr_pkg::S_UP_RD2:   cmd.op = kcsr_pkg::OP_UP_RD2;
      kcsr_pkg::S_UP_WR:    cmd.op = kcsr_pkg::OP_UP_WR;
      kcsr_pkg::S_PF_INIT:  cmd.op = kcsr_pkg::OP_PF_INIT;
      kcsr_pkg::S_PF_RD:    cmd.op = kcsr_pkg::OP_PF_RD;
      kcsr_pkg::S_PF_ACC:   cmd.op = kcsr_pkg::OP_PF_ACC;
      kcsr_pkg::S_CM_RD:    cmd.op = kcsr_pkg::OP_CM_RD;
      kcsr_pkg::S_CM_W1:    cmd.op = kcsr_pkg::OP_CM_W1;
      kcsr_pkg::S_CM_W2:    cmd.op = kcsr_pkg::OP_CM_W2;
      kcsr_pkg::S_PAIR_ADV: cmd.op = kcsr_pkg::OP_PAIR_ADV;
      kcsr_pkg::S_EM_RD:    cmd.op = kcsr_pkg::OP_EM_RD;
      kcsr_pkg::S_EM_LD:    cmd.op = kcsr_pkg::OP_EM_LD;
      default:              cmd.op = kcsr_pkg::OP_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/kcsr_dp.sv =====
// ----------------------------------------------------------------------------
// kcsr_dp
// Datapath: weight, cluster, support and swap memories, counters and gain math.
// ----------------------------------------------------------------------------
`default_nettype none

module kcsr_dp #(
  parameter int MAX_VERTICES = kcsr_pkg::MAX_VERTICES_DEF,
  parameter int MAX_CLUSTERS = kcsr_pkg::MAX_CLUSTERS_DEF,
  parameter int WEIGHT_BITS  = kcsr_pkg::WEIGHT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  kcsr_pkg::cmd_t      cmd,
  output kcsr_pkg::status_t   status,
  input  logic                in_valid,
  input  kcsr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output kcsr_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  localparam int M   = MAX_VERTICES;
  localparam int VB  = $clog2(M);
  localparam int CW  = $clog2(M + 1);
  localparam int WA  = $clog2(M * M);
  localparam int SEQ = M / 2;
  localparam int SQA = $clog2(SEQ);
  localparam int SB  = $clog2(SEQ + 1);
  localparam int CCW = $clog2(MAX_CLUSTERS + 2);
  localparam int WB  = WEIGHT_BITS;
  localparam int WD  = kcsr_pkg::WIDE_BITS;
  localparam int CB  = kcsr_pkg::CID_BITS;

  function automatic logic [WA-1:0] maddr(input logic [VB-1:0] r, input logic [VB-1:0] c);
    return WA'(int'(r) * M + int'(c));
  endfunction

  function automatic logic signed [WD-1:0] zx(input logic [WB-1:0] w);
    return $signed({{(WD-WB){1'b0}}, w});
  endfunction

  // configuration
  logic [6:0] cfg_vc;
  logic [4:0] cfg_cc;
  logic [CW-1:0]  n_use;
  logic [CCW-1:0] nc_use;

  always_comb begin
    if (int'(cfg_vc) > M) n_use = CW'(M);
    else if (cfg_vc == 7'd0) n_use = CW'(1);
    else n_use = CW'(cfg_vc);
    if (int'(cfg_cc) > MAX_CLUSTERS) nc_use = CCW'(MAX_CLUSTERS);
    else nc_use = CCW'(cfg_cc);
  end

  // control registers
  kcsr_pkg::in_item_t item_q;
  logic [CW-1:0]  v, u, a, b, na, nb;
  logic [SB-1:0]  steps, k, commit;
  logic [CCW-1:0] ca, cb;
  logic [WA-1:0]  clr;
  logic [M-1:0]   in_a, in_b, locked;
  logic           found;
  logic [VB-1:0]  pa, pb;
  logic signed [31:0] acc_a, acc_b, best, total, best_tot;
  logic signed [WD-1:0] da;
  logic [WB-1:0]  wa_q;
  kcsr_pkg::out_item_t out_q;

  // memory ports
  logic          w_we;
  logic [WA-1:0] w_waddr, w_raddr;
  logic [WB-1:0] w_wdata, w_rd;
  logic          c_we;
  logic [VB-1:0] c_waddr, c_raddr;
  logic [CB-1:0] c_wdata, c_rd;
  logic          s_we;
  logic [VB-1:0] s_waddr, s_raddr;
  logic [31:0]   sa_wdata, sb_wdata, sa_rd, sb_rd;
  logic          g_we;
  logic [SQA-1:0] g_waddr, g_raddr, p_waddr, p_raddr;
  logic [31:0]   g_rd;
  logic          p_we;
  logic [2*VB-1:0] p_rd;

  kcsr_ram #(.WIDTH(WB), .DEPTH(M*M)) u_wmem (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_rd));
  kcsr_ram #(.WIDTH(CB), .DEPTH(M)) u_cmem (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rd));
  kcsr_ram #(.WIDTH(32), .DEPTH(M)) u_samem (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(sa_wdata), .raddr(s_raddr), .rdata(sa_rd));
  kcsr_ram #(.WIDTH(32), .DEPTH(M)) u_sbmem (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(sb_wdata), .raddr(s_raddr), .rdata(sb_rd));
  kcsr_ram #(.WIDTH(32), .DEPTH(SEQ)) u_gmem (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(best), .raddr(g_raddr), .rdata(g_rd));
  kcsr_ram #(.WIDTH(2*VB), .DEPTH(SEQ)) u_pmem (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata({pa, pb}), .raddr(p_raddr), .rdata(p_rd));

  // derived status
  logic fire, edge_ok, clus_ok, out_free;
  logic [VB-1:0] vi, ui, ai, bi;
  logic [WB-1:0] w_in, wb_cur, w_su;
  logic signed [31:0] g_cur, t_cur, sa_new, sb_new;

  assign vi = v[VB-1:0];
  assign ui = u[VB-1:0];
  assign ai = a[VB-1:0];
  assign bi = b[VB-1:0];
  assign fire     = in_valid && (cmd.op == kcsr_pkg::OP_IDLE);
  assign edge_ok  = (int'(in_data.vertex_a) < M) && (int'(in_data.vertex_b) < M);
  assign clus_ok  = (int'(in_data.vertex_a) < M);
  assign out_free = !out_valid || !out_stall;
  assign w_in     = WB'(in_data.edge_weight);
  // diagonal weights never count toward support
  assign w_su     = (u == v) ? '0 : w_rd;
  assign wb_cur   = (vi == pb) ? '0 : w_rd;
  assign g_cur    = kcsr_pkg::sat32(da + kcsr_pkg::sx(sa_rd) - kcsr_pkg::sx(sb_rd)
                                    - (zx(w_rd) <<< 1));
  assign t_cur    = kcsr_pkg::sat32(kcsr_pkg::sx(total) + kcsr_pkg::sx(g_rd));
  assign sa_new   = kcsr_pkg::sat32(kcsr_pkg::sx(sa_rd) - zx(wa_q) + zx(wb_cur));
  assign sb_new   = kcsr_pkg::sat32(kcsr_pkg::sx(sb_rd) + zx(wa_q) - zx(wb_cur));

  always_comb begin
    status.fire        = fire;
    status.opcode      = in_data.opcode;
    status.edge_ok     = edge_ok;
    status.clr_done    = (clr == WA'(M * M - 1));
    status.pair_ok     = (cb < nc_use);
    status.v_last      = (v == n_use - CW'(1));
    status.u_last      = (u == n_use - CW'(1));
    status.size_ok     = (na >= CW'(2)) && (nb >= CW'(2));
    status.steps_full  = (steps == SB'(SEQ));
    status.a_end       = (a == n_use);
    status.elig_a      = in_a[ai] && !locked[ai];
    status.b_end       = (b == n_use);
    status.elig_b      = in_b[bi] && !locked[bi];
    status.found       = found;
    status.k_at_steps  = (k == steps);
    status.k_at_commit = (k == commit);
    status.out_free    = out_free;
  end

  // memory control
  always_comb begin
    w_we = 1'b0;  w_waddr = clr;  w_wdata = '0;  w_raddr = maddr(vi, ui);
    c_we = 1'b0;  c_waddr = in_data.vertex_a[VB-1:0];  c_wdata = in_data.cluster_id;
    c_raddr = vi;
    s_we = 1'b0;  s_waddr = vi;  sa_wdata = acc_a;  sb_wdata = acc_b;  s_raddr = vi;
    g_we = 1'b0;  g_waddr = steps[SQA-1:0];  g_raddr = k[SQA-1:0];
    p_we = 1'b0;  p_waddr = steps[SQA-1:0];  p_raddr = k[SQA-1:0];
    unique case (cmd.op)
      kcsr_pkg::OP_CLEAR: begin
        w_we = 1'b1;
      end
      kcsr_pkg::OP_IDLE: begin
        w_waddr = maddr(in_data.vertex_a[VB-1:0], in_data.vertex_b[VB-1:0]);
        w_wdata = w_in;
        w_we    = fire && (in_data.opcode == kcsr_pkg::OPC_EDGE) && edge_ok;
        c_we    = fire && (in_data.opcode == kcsr_pkg::OPC_CLUSTER) && clus_ok;
      end
      kcsr_pkg::OP_EDGE2: begin
        w_waddr = maddr(item_q.vertex_b[VB-1:0], item_q.vertex_a[VB-1:0]);
        w_wdata = WB'(item_q.edge_weight);
        w_we    = 1'b1;
      end
      kcsr_pkg::OP_SU_WR: begin
        s_we = 1'b1;
      end
      kcsr_pkg::OP_SR_A: begin
        s_raddr = ai;
      end
      kcsr_pkg::OP_SR_B: begin
        s_raddr = bi;
        w_raddr = maddr(ai, bi);
      end
      kcsr_pkg::OP_SR_END: begin
        g_we = found;
        p_we = found;
      end
      kcsr_pkg::OP_UP_RD1: begin
        w_raddr = maddr(vi, pa);
      end
      kcsr_pkg::OP_UP_RD2: begin
        w_raddr = maddr(vi, pb);
      end
      kcsr_pkg::OP_UP_WR: begin
        s_we     = 1'b1;
        sa_wdata = sa_new;
        sb_wdata = sb_new;
      end
      kcsr_pkg::OP_CM_W1: begin
        c_we    = 1'b1;
        c_waddr = p_rd[2*VB-1:VB];
        c_wdata = CB'(cb);
      end
      kcsr_pkg::OP_CM_W2: begin
        c_we    = 1'b1;
        c_waddr = p_rd[VB-1:0];
        c_wdata = CB'(ca);
      end
      default: begin
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_vc    <= 7'(kcsr_pkg::VC_RESET);
      cfg_cc    <= 5'(kcsr_pkg::CC_RESET);
      clr       <= '0;
      out_valid <= 1'b0;
      locked    <= '0;
      in_a      <= '0;
      in_b      <= '0;
      found     <= 1'b0;
      v <= '0; u <= '0; a <= '0; b <= '0; na <= '0; nb <= '0;
      steps <= '0; k <= '0; commit <= '0; ca <= '0; cb <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          kcsr_pkg::REG_VERTEX_COUNT:  cfg_vc <= cfg_data[6:0];
          kcsr_pkg::REG_CLUSTER_COUNT: cfg_cc <= cfg_data[4:0];
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (cmd.op)
        kcsr_pkg::OP_CLEAR: clr <= clr + WA'(1);
        kcsr_pkg::OP_IDLE: begin
          if (fire) begin
            item_q <= in_data;
            ca     <= '0;
            cb     <= CCW'(1);
          end
        end
        kcsr_pkg::OP_PAIR: begin
          in_a <= '0;  in_b <= '0;
          v <= '0;  na <= '0;  nb <= '0;
        end
        kcsr_pkg::OP_CL_CAP: begin
          in_a[vi] <= (8'(c_rd) == 8'(ca));
          in_b[vi] <= (8'(c_rd) == 8'(cb));
          if (8'(c_rd) == 8'(ca)) na <= na + CW'(1);
          if (8'(c_rd) == 8'(cb)) nb <= nb + CW'(1);
          v <= v + CW'(1);
        end
        kcsr_pkg::OP_CL_CHK: begin
          v <= '0;  u <= '0;  steps <= '0;  locked <= '0;
          acc_a <= '0;  acc_b <= '0;
        end
        kcsr_pkg::OP_SU_ACC: begin
          if (in_a[ui]) acc_a <= kcsr_pkg::sat32(kcsr_pkg::sx(acc_a) + zx(w_su));
          if (in_b[ui]) acc_b <= kcsr_pkg::sat32(kcsr_pkg::sx(acc_b) + zx(w_su));
          u <= u + CW'(1);
        end
        kcsr_pkg::OP_SU_WR: begin
          acc_a <= '0;  acc_b <= '0;  u <= '0;
          v <= v + CW'(1);
        end
        kcsr_pkg::OP_SR_INIT: begin
          a <= '0;  found <= 1'b0;
        end
        kcsr_pkg::OP_SR_A: begin
          if (!status.a_end) begin
            if (status.elig_a) b <= '0;
            else a <= a + CW'(1);
          end
        end
        kcsr_pkg::OP_SR_ALAT: begin
          da <= kcsr_pkg::sx(sb_rd) - kcsr_pkg::sx(sa_rd);
        end
        kcsr_pkg::OP_SR_B: begin
          if (status.b_end) a <= a + CW'(1);
          else if (!status.elig_b) b <= b + CW'(1);
        end
        kcsr_pkg::OP_SR_BCALC: begin
          // first strictly higher gain wins
          if (!found || (g_cur > best)) begin
            found <= 1'b1;
            best  <= g_cur;
            pa    <= ai;
            pb    <= bi;
          end
          b <= b + CW'(1);
        end
        kcsr_pkg::OP_SR_END: begin
          if (found) begin
            steps      <= steps + SB'(1);
            locked[pa] <= 1'b1;
            locked[pb] <= 1'b1;
            v          <= '0;
          end
        end
        kcsr_pkg::OP_UP_RD2: begin
          wa_q <= (vi == pa) ? '0 : w_rd;
        end
        kcsr_pkg::OP_UP_WR: begin
          v <= v + CW'(1);
        end
        kcsr_pkg::OP_PF_INIT: begin
          k <= '0;  commit <= '0;  total <= '0;  best_tot <= '0;
        end
        kcsr_pkg::OP_PF_RD: begin
          if (status.k_at_steps) k <= '0;
        end
        kcsr_pkg::OP_PF_ACC: begin
          total <= t_cur;
          if (t_cur > best_tot) begin
            best_tot <= t_cur;
            commit   <= k + SB'(1);
          end
          k <= k + SB'(1);
        end
        kcsr_pkg::OP_CM_W2: begin
          k <= k + SB'(1);
        end
        kcsr_pkg::OP_PAIR_ADV: begin
          if (cb + CCW'(1) == nc_use) begin
            ca <= ca + CCW'(1);
            cb <= ca + CCW'(2);
          end else begin
            cb <= cb + CCW'(1);
          end
        end
        kcsr_pkg::OP_EM_LD: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            out_q.out_vertex  <= 6'(v);
            out_q.out_cluster <= c_rd;
            out_q.last        <= status.v_last;
            v                 <= v + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_data = out_q;

  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == kcsr_pkg::OP_SR_END && found) |=> (locked[pa] && locked[pb]))
    else $error("chosen swap pair not locked");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == kcsr_pkg::OP_CM_RD) |-> (commit <= steps))
    else $error("commit prefix longer than swap sequence");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == kcsr_pkg::OP_EM_LD && out_valid && out_stall) |=>
      (out_valid && $stable(out_q)))
    else $error("pending result overwritten during emit");

endmodule

`default_nettype wire

// ===== src/kl_cluster_swap_refiner.sv =====
// ----------------------------------------------------------------------------
// kl_cluster_swap_refiner
// Kernighan-Lin pairwise cluster refinement over a loaded weighted graph.
// ----------------------------------------------------------------------------
//
//  channel | signals                              | transaction
//  --------+--------------------------------------+------------------------------
//  input   | in_valid, in_stall, in_data          | edge load, cluster load, run
//  output  | out_valid, out_stall, out_data       | one vertex and its cluster
//  config  | cfg_valid, cfg_ready, cfg_index/data | register write
//
//  after reset the weight memory is cleared, all MAX_VERTICES^2 entries (4096), with
//  in_stall high; config writes are taken throughout
//  cluster load: one write; edge load: a write, then its mirror in S_EDGE2 (one
//  weight memory write port); run: per cluster pair a cluster scan, per refined
//  pair a further support build, then per swap step a search and a support update,
//  then a gain prefix scan and the commit; emission reads one vertex at a time
//  through the one cluster memory read port; a stalled output holds the emit loop
//  reset is synchronous; the block only holds in_stall low while idle
//
`default_nettype none

module kl_cluster_swap_refiner #(
  parameter int MAX_VERTICES = kcsr_pkg::MAX_VERTICES_DEF,
  parameter int MAX_CLUSTERS = kcsr_pkg::MAX_CLUSTERS_DEF,
  parameter int WEIGHT_BITS  = kcsr_pkg::WEIGHT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  kcsr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output kcsr_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  kcsr_pkg::cmd_t    cmd;
  kcsr_pkg::status_t status;

  // config writes must arrive only while idle; the block does not enforce it and always takes them
  assign cfg_ready = 1'b1;

  // sequencer: walks cluster pairs, swap steps and emission
  kcsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // memories, counters and gain arithmetic
  kcsr_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cluster swap refiner: loads graphs, runs
// refinement under varied register settings and handshake pressure, and
// compares every emitted vertex against a built-in swap-refinement predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// scoreboard: mirrors graph state and predicts the emitted clusters
class cluster_refine_sb;
  logic [15:0] wmat [64][64];
  logic [3:0]  clu [64];
  int          vcount;
  int          ccount;
  kcsr_pkg::out_item_t emit_q [$];
  int          errors;

  function new();
    foreach (wmat[i, j]) wmat[i][j] = '0;
    foreach (clu[i]) clu[i] = '0;
    vcount = kcsr_pkg::VC_RESET;
    ccount = kcsr_pkg::CC_RESET;
    errors = 0;
  endfunction

  function int clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fff_ffff;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return int'(x);
  endfunction

  function longint edge_w(int u, int v);
    if (u == v) return 0;
    return longint'(wmat[u][v]);
  endfunction

  function void write_reg(logic [1:0] idx, logic [7:0] val);
    if (idx == kcsr_pkg::REG_VERTEX_COUNT) vcount = val[6:0];
    else if (idx == kcsr_pkg::REG_CLUSTER_COUNT) ccount = val[4:0];
  endfunction

  // variable-depth swap search between clusters ca and cb
  function void refine_pair(int n, int ca, int cb);
    int     sup_a [64];
    int     sup_b [64];
    bit     locked [64];
    int     gains [32];
    int     sw_a [32];
    int     sw_b [32];
    int     na, nb, steps, commit, g, best, pa, pb;
    bit     found;
    longint sa, sb, total, best_total;
    na = 0; nb = 0; steps = 0; commit = 0;
    for (int v = 0; v < n; v++) begin
      if (clu[v] == ca) na++;
      if (clu[v] == cb) nb++;
    end
    if (na < 2 || nb < 2) return;
    for (int v = 0; v < n; v++) begin
      sa = 0; sb = 0;
      for (int u = 0; u < n; u++) begin
        if (clu[u] == ca) sa = clamp32(sa + edge_w(v, u));
        if (clu[u] == cb) sb = clamp32(sb + edge_w(v, u));
      end
      sup_a[v] = int'(sa);
      sup_b[v] = int'(sb);
      locked[v] = 0;
    end
    while (steps < 32) begin
      found = 0; best = 0; pa = 0; pb = 0;
      for (int a = 0; a < n; a++) begin
        if (locked[a] || clu[a] != ca) continue;
        for (int b = 0; b < n; b++) begin
          if (locked[b] || clu[b] != cb) continue;
          g = clamp32(longint'(sup_b[a]) - sup_a[a] + longint'(sup_a[b]) - sup_b[b]
                      - 2 * edge_w(a, b));
          // first strictly highest gain wins
          if (!found || g > best) begin
            found = 1; best = g; pa = a; pb = b;
          end
        end
      end
      if (!found) break;
      gains[steps] = best;
      sw_a[steps] = pa;
      sw_b[steps] = pb;
      steps++;
      locked[pa] = 1;
      locked[pb] = 1;
      for (int v = 0; v < n; v++) begin
        sup_a[v] = clamp32(longint'(sup_a[v]) - edge_w(v, pa) + edge_w(v, pb));
        sup_b[v] = clamp32(longint'(sup_b[v]) + edge_w(v, pa) - edge_w(v, pb));
      end
    end
    total = 0; best_total = 0;
    for (int k = 0; k < steps; k++) begin
      total = clamp32(total + gains[k]);
      if (total > best_total) begin
        best_total = total;
        commit = k + 1;
      end
    end
    for (int k = 0; k < commit; k++) begin
      clu[sw_a[k]] = cb[3:0];
      clu[sw_b[k]] = ca[3:0];
    end
  endfunction

  // accepted input transaction
  function void note(kcsr_pkg::in_item_t it);
    int                  n, nc;
    kcsr_pkg::out_item_t o;
    case (it.opcode)
      kcsr_pkg::OPC_EDGE: begin
        wmat[it.vertex_a][it.vertex_b] = it.edge_weight;
        wmat[it.vertex_b][it.vertex_a] = it.edge_weight;
      end
      kcsr_pkg::OPC_CLUSTER: clu[it.vertex_a] = it.cluster_id;
      kcsr_pkg::OPC_RUN: begin
        n = (vcount > 64) ? 64 : ((vcount < 1) ? 1 : vcount);
        nc = (ccount > 16) ? 16 : ccount;
        for (int ca = 0; ca + 1 < nc; ca++)
          for (int cb = ca + 1; cb < nc; cb++)
            refine_pair(n, ca, cb);
        for (int v = 0; v < n; v++) begin
          o.out_vertex = v[5:0];
          o.out_cluster = clu[v];
          o.last = (v + 1 == n);
          emit_q = {emit_q, o};
        end
      end
      default: ;
    endcase
  endfunction

  // accepted output transaction
  function void check(kcsr_pkg::out_item_t got);
    kcsr_pkg::out_item_t want;
    if (emit_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: vertex %0d cluster %0d last %0b",
                 got.out_vertex, got.out_cluster, got.last);
      return;
    end
    want = emit_q.pop_front();
    if (got.out_vertex !== want.out_vertex || got.out_cluster !== want.out_cluster ||
        got.last !== want.last) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected v %0d c %0d l %0b, got v %0d c %0d l %0b",
                 want.out_vertex, want.out_cluster, want.last,
                 got.out_vertex, got.out_cluster, got.last);
    end
  endfunction
endclass

module testbench;

  localparam int LIMIT = 4_000_000;
  localparam logic [1:0] OPC_SPARE = 2'd3;

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_stall;
  kcsr_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  kcsr_pkg::out_item_t out_data;
  logic      cfg_valid = 0;
  logic      cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  cluster_refine_sb sb;
  int        idle_mode = 0;   // 0 none, 1 sender gaps, 2 receiver stalls, 3 both light
  int        hold_off = 0;    // long receiver hold-off, in cycles
  int        cycles = 0;

  kl_cluster_swap_refiner u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: check at the rising edge, choose next stall at the falling edge
  always begin
    @(posedge clk);
    if (!rst && out_valid && !out_stall) sb.check(out_data);
    @(negedge clk);
    if (hold_off > 0) begin
      hold_off = hold_off - 1;
      out_stall = 1;
    end else if (idle_mode == 2) out_stall = ($urandom_range(0, 99) < 58);
    else if (idle_mode == 3) out_stall = ($urandom_range(0, 99) < 13);
    else out_stall = 0;
  end

  // offer one input transaction and hold it until accepted
  task automatic send(kcsr_pkg::in_item_t it);
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 58 : ((idle_mode == 3) ? 13 : 0);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_data = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note(it);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid = 0;
  endtask

  // block is idle once every expected result is back and loads have settled
  task automatic drain();
    release_input();
    while (sb.emit_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic kcsr_pkg::in_item_t mk(logic [1:0] op, int a, int b, int w, int c);
    kcsr_pkg::in_item_t it;
    it.opcode = op;
    it.vertex_a = a[5:0];
    it.vertex_b = b[5:0];
    it.edge_weight = w[15:0];
    it.cluster_id = c[3:0];
    return it;
  endfunction

  // random transaction, mostly loads among vertices in use
  function automatic kcsr_pkg::in_item_t rand_item(int n, int nc);
    int r, a, b, hi;
    r = $urandom_range(0, 99);
    hi = (n < 1) ? 0 : ((n > 64) ? 63 : n - 1);
    a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, hi);
    b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, hi);
    if (r < 55)
      return mk(kcsr_pkg::OPC_EDGE, a, b, $urandom_range(0, 65535), $urandom_range(0, 15));
    if (r < 88)
      return mk(kcsr_pkg::OPC_CLUSTER, a, b, $urandom_range(0, 65535),
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                            : $urandom_range(0, (nc < 2) ? 1 : nc - 1));
    if (r < 95)
      return mk(kcsr_pkg::OPC_RUN, a, b, $urandom_range(0, 65535), $urandom_range(0, 15));
    return mk(OPC_SPARE, a, b, $urandom_range(0, 65535), $urandom_range(0, 15));
  endfunction

  // register settings per phase, extremes among them; large counts clamp
  int vc_set [6] = '{0, 6, 9, 127, 12, 5};
  int cc_set [6] = '{31, 3, 2, 4, 0, 1};

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // every vertex gets a cluster before any run, three groups to keep runs short
    for (int v = 0; v < 64; v++) send(mk(kcsr_pkg::OPC_CLUSTER, v, 0, 0, v % 3));

    // directed: weight extremes, self-loop, top vertex, high cluster id,
    // unused opcode, then a full-size run at the reset settings
    send(mk(kcsr_pkg::OPC_EDGE, 0, 63, 16'hffff, 0));
    send(mk(kcsr_pkg::OPC_EDGE, 63, 0, 0, 15));
    send(mk(kcsr_pkg::OPC_EDGE, 0, 1, 16'hffff, 0));
    send(mk(kcsr_pkg::OPC_EDGE, 2, 3, 16'h0100, 0));
    send(mk(kcsr_pkg::OPC_EDGE, 5, 5, 16'hffff, 0));
    send(mk(kcsr_pkg::OPC_EDGE, 1, 4, 16'h8000, 0));
    send(mk(kcsr_pkg::OPC_EDGE, 3, 6, 16'h00ff, 0));
    send(mk(kcsr_pkg::OPC_CLUSTER, 62, 0, 0, 15));
    send(mk(OPC_SPARE, 63, 63, 16'hffff, 15));
    send(mk(kcsr_pkg::OPC_RUN, 0, 0, 0, 0));
    drain();

    // small graph with equal gains, so first-found tie order decides
    write_reg(kcsr_pkg::REG_VERTEX_COUNT, 8'd4);
    write_reg(kcsr_pkg::REG_CLUSTER_COUNT, 8'd2);
    send(mk(kcsr_pkg::OPC_CLUSTER, 0, 0, 0, 0));
    send(mk(kcsr_pkg::OPC_CLUSTER, 1, 0, 0, 1));
    send(mk(kcsr_pkg::OPC_CLUSTER, 2, 0, 0, 0));
    send(mk(kcsr_pkg::OPC_CLUSTER, 3, 0, 0, 1));
    send(mk(kcsr_pkg::OPC_EDGE, 0, 1, 16'h0200, 0));
    send(mk(kcsr_pkg::OPC_EDGE, 2, 3, 16'h0200, 0));
    send(mk(kcsr_pkg::OPC_EDGE, 0, 2, 0, 0));
    send(mk(kcsr_pkg::OPC_RUN, 0, 0, 0, 0));
    send(mk(kcsr_pkg::OPC_CLUSTER, 3, 0, 0, 15));
    send(mk(kcsr_pkg::OPC_RUN, 0, 0, 0, 0));
    drain();

    // random phases, each under its own settings and one of the idling patterns
    for (int p = 0; p < 6; p++) begin
      write_reg(kcsr_pkg::REG_VERTEX_COUNT, vc_set[p][7:0]);
      write_reg(kcsr_pkg::REG_CLUSTER_COUNT, cc_set[p][7:0]);
      idle_mode = p % 4;
      for (int i = 0; i < 3; i++) begin
        if (p == 1 && i == 1) begin
          // receiver holds off long while the sender keeps offering
          send(mk(kcsr_pkg::OPC_RUN, 0, 0, 0, 0));
          hold_off = 400;
        end
        if (p == 2 && i == 1) drain();   // sender pauses until all results are back
        send(rand_item(vc_set[p], cc_set[p]));
      end
      send(mk(kcsr_pkg::OPC_RUN, 0, 0, 0, 0));
      drain();
    end

    // back to the reset counts for one more run
    write_reg(kcsr_pkg::REG_VERTEX_COUNT, 8'd64);
    write_reg(kcsr_pkg::REG_CLUSTER_COUNT, 8'd16);
    idle_mode = 0;
    send(mk(kcsr_pkg::OPC_RUN, 0, 0, 0, 0));
    drain();
    repeat (200) @(posedge clk);

    if (sb.errors == 0 && sb.emit_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== kl_cluster_swap_refiner.f =====
src/kcsr_pkg.sv
src/kcsr_ram.sv
src/kcsr_ctrl.sv
src/kcsr_dp.sv
src/kl_cluster_swap_refiner.sv
tb/testbench.sv
